// ----- design/rcfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg : shared types and constants of the RC frame deframer
// Byte positions, status and register codes, and the parser-to-top struct.
// ----------------------------------------------------------------------------
package rcfd_pkg;

   localparam int          POS_W        = 9;
   localparam logic [7:0]  HEADER_BYTE  = 8'hBB;
   localparam logic [7:0]  MIN_PAYLOAD  = 8'd22;
   localparam logic [17:0] MIRROR_BASE  = 18'd3000;  // 2 * 1500
   localparam int          CSR_IDX_W    = 2;
   localparam int          CSR_DATA_W   = 16;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_SUM = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROLL_OFFSET  = 2'd0,
      CSR_PITCH_OFFSET = 2'd1,
      CSR_YAW_OFFSET   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        at_end;     // current beat is the checksum byte
      logic        short_len;
      logic        sum_match;  // running sum equals current byte
      logic [15:0] roll_word;
      logic [15:0] pitch_word;
      logic [15:0] yaw_word;
      logic [15:0] thrust_word;
      logic [7:0]  mode_byte;
      logic [7:0]  lock_byte;
   } frame_info_type;

endpackage

// ----- design/rcfd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_parser : header hunt, length tracking, checksum sum and field capture
// Advances one byte position per accepted beat; restarts on a non-header byte and after checksum.
// ----------------------------------------------------------------------------
module rcfd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    beat_accept,
   input  logic [7:0]              rx_byte,
   output rcfd_pkg::frame_info_type info
);
   import rcfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [15:0]      roll_ff, roll_in, pitch_ff, pitch_in;
   logic [15:0]      yaw_ff, yaw_in, thrust_ff, thrust_in;
   logic [7:0]       mode_ff, mode_in, lock_ff, lock_in;
   logic             in_payload;

   assign in_payload = (pos_ff > POS_W'(3)) &&
                       (pos_ff < ({1'b0, len_ff} + POS_W'(4)));

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      roll_in   = roll_ff;
      pitch_in  = pitch_ff;
      yaw_in    = yaw_ff;
      thrust_in = thrust_ff;
      mode_in   = mode_ff;
      lock_in   = lock_ff;
      if (pos_ff <= POS_W'(1)) begin
         if (rx_byte == HEADER_BYTE) begin
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in = '0;
            len_in = '0;
            sum_in = '0;
         end
      end else if (pos_ff == POS_W'(2)) begin
         sum_in = sum_ff + rx_byte;
         pos_in = POS_W'(3);
      end else if (pos_ff == POS_W'(3)) begin
         len_in = rx_byte;
         sum_in = sum_ff + rx_byte;
         pos_in = POS_W'(4);
      end else if (in_payload) begin
         sum_in = sum_ff + rx_byte;
         pos_in = pos_ff + POS_W'(1);
         case (pos_ff)
            POS_W'(4):  roll_in[15:8]   = rx_byte;
            POS_W'(5):  roll_in[7:0]    = rx_byte;
            POS_W'(6):  pitch_in[15:8]  = rx_byte;
            POS_W'(7):  pitch_in[7:0]   = rx_byte;
            POS_W'(8):  yaw_in[15:8]    = rx_byte;
            POS_W'(9):  yaw_in[7:0]     = rx_byte;
            POS_W'(10): thrust_in[15:8] = rx_byte;
            POS_W'(11): thrust_in[7:0]  = rx_byte;
            POS_W'(24): mode_in         = rx_byte;
            POS_W'(25): lock_in         = rx_byte;
            default: ;
         endcase
      end else begin
         pos_in = '0;
         len_in = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         roll_ff   <= '0;
         pitch_ff  <= '0;
         yaw_ff    <= '0;
         thrust_ff <= '0;
         mode_ff   <= '0;
         lock_ff   <= '0;
      end else if (beat_accept) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         roll_ff   <= roll_in;
         pitch_ff  <= pitch_in;
         yaw_ff    <= yaw_in;
         thrust_ff <= thrust_in;
         mode_ff   <= mode_in;
         lock_ff   <= lock_in;
      end
   end

   assign info.at_end      = (pos_ff > POS_W'(3)) && !in_payload;
   assign info.short_len   = (len_ff < MIN_PAYLOAD);
   assign info.sum_match   = (sum_ff == rx_byte);
   assign info.roll_word   = roll_ff;
   assign info.pitch_word  = pitch_ff;
   assign info.yaw_word    = yaw_ff;
   assign info.thrust_word = thrust_ff;
   assign info.mode_byte   = mode_ff;
   assign info.lock_byte   = lock_ff;

endmodule

// ----- design/rc_frame_deframer_checksum_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_frame_deframer_checksum_unit : RC link deframer with checksum and arming
// Channel | Ports        | Carries
// req     | valid/stall  | one link byte per beat
// rsp     | valid/stall  | frame status, trimmed setpoints, mode, arm flags
// csr     | write enable | roll, pitch and yaw trims
// One byte per cycle while req_stall is low; a result appears the cycle after the checksum byte is accepted.
// Synchronous active-high reset returns to header hunt, locked, trims zero.
// While a result waits under rsp_stall, non-checksum bytes are still taken;
// only a checksum byte is held back until the result register frees.
// ----------------------------------------------------------------------------
module rc_frame_deframer_checksum_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_frame_status,
   output logic signed [17:0]                   rsp_roll_value,
   output logic signed [17:0]                   rsp_pitch_value,
   output logic signed [17:0]                   rsp_yaw_value,
   output logic [15:0]                          rsp_thrust_value,
   output logic [7:0]                           rsp_flight_mode,
   output logic                                 rsp_armed,
   output logic                                 rsp_arm_edge,
   input  logic                                 csr_write_enable,
   input  logic [rcfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import rcfd_pkg::*;

   frame_info_type info;
   logic           beat_accept, end_accept, frame_ok, edge_now;

   logic [15:0] roll_off_ff, pitch_off_ff, yaw_off_ff;
   logic        armed_ff, armed_in;
   logic [7:0]  prev_lock_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [17:0] roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic [15:0] thrust_ff, thrust_in;
   logic [7:0]  mode_ff, mode_in;
   logic        armed_out_ff, armed_out_in, edge_ff, edge_in;

   assign req_stall   = rsp_valid_ff && rsp_stall && info.at_end;
   assign beat_accept = req_valid && !req_stall;
   assign end_accept  = beat_accept && info.at_end;

   rcfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .rx_byte     (req_rx_byte),
      .info        (info)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_off_ff  <= '0;
         pitch_off_ff <= '0;
         yaw_off_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROLL_OFFSET:  roll_off_ff  <= csr_write_data;
            CSR_PITCH_OFFSET: pitch_off_ff <= csr_write_data;
            CSR_YAW_OFFSET:   yaw_off_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      frame_ok     = !info.short_len && info.sum_match;
      edge_now     = (info.lock_byte == 8'd1) && (prev_lock_ff == 8'd0);
      armed_in     = armed_ff;
      if (edge_now) begin
         armed_in = 1'b1;
      end else if (info.lock_byte == 8'd0) begin
         armed_in = 1'b0;
      end
      status_in    = info.short_len ? STATUS_SHORT :
                     (info.sum_match ? STATUS_OK : STATUS_BAD_SUM);
      roll_in      = '0;
      pitch_in     = '0;
      yaw_in       = '0;
      thrust_in    = '0;
      mode_in      = '0;
      armed_out_in = 1'b0;
      edge_in      = 1'b0;
      if (frame_ok) begin
         roll_in      = {2'b00, info.roll_word} + {{2{roll_off_ff[15]}}, roll_off_ff};
         pitch_in     = MIRROR_BASE - {2'b00, info.pitch_word}
                        + {{2{pitch_off_ff[15]}}, pitch_off_ff};
         yaw_in       = {2'b00, info.yaw_word} + {{2{yaw_off_ff[15]}}, yaw_off_ff};
         thrust_in    = info.thrust_word;
         mode_in      = info.mode_byte;
         armed_out_in = armed_in;
         edge_in      = edge_now;
      end
      rsp_valid_in = end_accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         prev_lock_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (end_accept && frame_ok) begin
            armed_ff     <= armed_in;
            prev_lock_ff <= info.lock_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (end_accept) begin
         status_ff    <= status_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         thrust_ff    <= thrust_in;
         mode_ff      <= mode_in;
         armed_out_ff <= armed_out_in;
         edge_ff      <= edge_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_roll_value   = roll_ff;
   assign rsp_pitch_value  = pitch_ff;
   assign rsp_yaw_value    = yaw_ff;
   assign rsp_thrust_value = thrust_ff;
   assign rsp_flight_mode  = mode_ff;
   assign rsp_armed        = armed_out_ff;
   assign rsp_arm_edge     = edge_ff;

endmodule

// ----- design/rcfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_checker : port-level checks on the deframer result channel
// Result beat hold under stall, rejected-frame zeroing and arm edge sense.
// ----------------------------------------------------------------------------
module rcfd_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_frame_status,
   input logic signed [17:0]  rsp_roll_value,
   input logic signed [17:0]  rsp_pitch_value,
   input logic signed [17:0]  rsp_yaw_value,
   input logic [15:0]         rsp_thrust_value,
   input logic [7:0]          rsp_flight_mode,
   input logic                rsp_armed,
   input logic                rsp_arm_edge
);
   import rcfd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_frame_status) && $stable(rsp_roll_value)
         && $stable(rsp_pitch_value) && $stable(rsp_armed))
      else $error("result beat changed under stall");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status != STATUS_OK) |->
         rsp_roll_value == 18'sd0 && rsp_pitch_value == 18'sd0 &&
         rsp_yaw_value == 18'sd0 && rsp_thrust_value == 16'd0 &&
         rsp_flight_mode == 8'd0 && !rsp_armed && !rsp_arm_edge)
      else $error("rejected frame carries data");

   a_edge_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arm_edge |-> rsp_armed && (rsp_frame_status == STATUS_OK))
      else $error("arm edge without armed accepted frame");

endmodule

bind rc_frame_deframer_checksum_unit rcfd_checker u_rcfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_status (rsp_frame_status),
   .rsp_roll_value   (rsp_roll_value),
   .rsp_pitch_value  (rsp_pitch_value),
   .rsp_yaw_value    (rsp_yaw_value),
   .rsp_thrust_value (rsp_thrust_value),
   .rsp_flight_mode  (rsp_flight_mode),
   .rsp_armed        (rsp_armed),
   .rsp_arm_edge     (rsp_arm_edge)
);
